/* hdl/ndt_pkg.sv */
`timescale 1ns / 1ps

package ndt_pkg;

   // Table geometry
   localparam int TABLE_ENTRIES = 16;
   localparam int NAME_CHARS    = 8;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

   // Field widths
   localparam int CMD_W    = 2;
   localparam int NAME_W   = 64;
   localparam int SECTOR_W = 16;
   localparam int STATUS_W = 2;
   localparam int INDEX_W  = 4;
   localparam int CFG_W    = 5;

   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

   // Stream payload widths, padded to whole bytes
   localparam int REQ_BITS = CMD_W + NAME_W + SECTOR_W;
   localparam int REQ_W    = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS = STATUS_W + SECTOR_W + INDEX_W;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_FIND   = 2'd0,
      CMD_ADD    = 2'd1,
      CMD_REMOVE = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_PRESENT   = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_APPLY
   } state_type;

   // Write request from the sequencer to the entry store
   typedef struct packed {
      logic                write;
      logic                clear;
      logic [IDX_W-1:0]    addr;
      logic [NAME_W-1:0]   name;
      logic [SECTOR_W-1:0] sector;
   } wr_type;

   // Registered read data from the entry store
   typedef struct packed {
      logic                valid;
      logic [NAME_W-1:0]   name;
      logic [SECTOR_W-1:0] sector;
   } rd_type;

   // One result item
   typedef struct packed {
      logic [INDEX_W-1:0]  index;
      logic [SECTOR_W-1:0] sector;
      status_type          status;
   } result_type;

   // Keep bytes up to the first zero byte, at most NAME_CHARS of them
   function automatic logic [NAME_W-1:0] clean_name(input logic [NAME_W-1:0] raw);
      logic [NAME_W-1:0] res;
      logic              stop;
      res  = '0;
      stop = 1'b0;
      for (int b = 0; b < NAME_W / 8; b++) begin
         if (raw[8*b +: 8] == 8'd0 || b >= NAME_CHARS) begin
            stop = 1'b1;
         end
         if (!stop) begin
            res[8*b +: 8] = raw[8*b +: 8];
         end
      end
      return res;
   endfunction

   // Active table size, capped at the built depth
   function automatic logic [CNT_W-1:0] active_size(input logic [CFG_W-1:0] cfg);
      logic [CNT_W-1:0] n;
      if (int'(cfg) > TABLE_ENTRIES) begin
         n = CNT_W'(TABLE_ENTRIES);
      end else begin
         n = CNT_W'(cfg);
      end
      return n;
   endfunction

endpackage

/* hdl/ndt_entry_store.sv */
`timescale 1ns / 1ps

module ndt_entry_store (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [ndt_pkg::IDX_W-1:0]  rd_addr,
   input  ndt_pkg::wr_type            wr,
   output ndt_pkg::rd_type            rd
);

   logic [ndt_pkg::NAME_W-1:0]   name_mem   [ndt_pkg::TABLE_ENTRIES];
   logic [ndt_pkg::SECTOR_W-1:0] sector_mem [ndt_pkg::TABLE_ENTRIES];
   logic [ndt_pkg::TABLE_ENTRIES-1:0] valid_ff;
   logic                         rd_valid_ff;
   logic [ndt_pkg::NAME_W-1:0]   rd_name_ff;
   logic [ndt_pkg::SECTOR_W-1:0] rd_sector_ff;

   // Name and sector memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr.write) begin
         name_mem[wr.addr]   <= wr.name;
         sector_mem[wr.addr] <= wr.sector;
      end
      rd_name_ff   <= name_mem[rd_addr];
      rd_sector_ff <= sector_mem[rd_addr];
   end

   // Valid marks clear at reset; set on fill, drop on remove
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.write) begin
            valid_ff[wr.addr] <= 1'b1;
         end else if (wr.clear) begin
            valid_ff[wr.addr] <= 1'b0;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd.valid  = rd_valid_ff;
   assign rd.name   = rd_name_ff;
   assign rd.sector = rd_sector_ff;

endmodule

/* hdl/ndt_scan_ctrl.sv */
`timescale 1ns / 1ps

module ndt_scan_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [ndt_pkg::CFG_W-1:0]     entries_in_use,
   input  logic                          cmd_valid,
   output logic                          cmd_ready,
   input  logic [ndt_pkg::CMD_W-1:0]     cmd_code,
   input  logic [ndt_pkg::NAME_W-1:0]    cmd_name,
   input  logic [ndt_pkg::SECTOR_W-1:0]  cmd_sector,
   output logic                          res_valid,
   input  logic                          res_ready,
   output ndt_pkg::result_type           res,
   output logic [ndt_pkg::IDX_W-1:0]     rd_addr,
   input  ndt_pkg::rd_type               rd,
   output ndt_pkg::wr_type               wr
);

   ndt_pkg::state_type             state_ff, state_in;
   logic [ndt_pkg::IDX_W-1:0]      idx_ff, idx_in;
   logic [ndt_pkg::CNT_W-1:0]      size_ff, size_in;
   logic                           live_ff, live_in;
   logic [ndt_pkg::IDX_W-1:0]      live_idx_ff, live_idx_in;
   logic [ndt_pkg::CMD_W-1:0]      cmd_ff, cmd_in;
   logic [ndt_pkg::NAME_W-1:0]     name_ff, name_in;
   logic [ndt_pkg::SECTOR_W-1:0]   sector_ff, sector_in;
   logic                           hit_ff, hit_in;
   logic [ndt_pkg::IDX_W-1:0]      hit_idx_ff, hit_idx_in;
   logic [ndt_pkg::SECTOR_W-1:0]   hit_sector_ff, hit_sector_in;
   logic                           free_ff, free_in;
   logic [ndt_pkg::IDX_W-1:0]      free_idx_ff, free_idx_in;
   logic [ndt_pkg::CNT_W-1:0]      next_count;
   logic                           match;
   logic                           empty;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ndt_pkg::S_IDLE;
         live_ff  <= 1'b0;
         hit_ff   <= 1'b0;
         free_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         live_ff  <= live_in;
         hit_ff   <= hit_in;
         free_ff  <= free_in;
      end
   end

   // Item and scan payload
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      size_ff       <= size_in;
      live_idx_ff   <= live_idx_in;
      cmd_ff        <= cmd_in;
      name_ff       <= name_in;
      sector_ff     <= sector_in;
      hit_idx_ff    <= hit_idx_in;
      hit_sector_ff <= hit_sector_in;
      free_idx_ff   <= free_idx_in;
   end

   // Shared compare unit: one stored entry against the cleaned name per cycle
   assign match      = live_ff && rd.valid && (rd.name == name_ff);
   assign empty      = live_ff && !rd.valid;
   assign next_count = ndt_pkg::CNT_W'(idx_ff) + ndt_pkg::CNT_W'(1);
   assign rd_addr    = idx_ff;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      size_in       = size_ff;
      live_in       = 1'b0;
      live_idx_in   = idx_ff;
      cmd_in        = cmd_ff;
      name_in       = name_ff;
      sector_in     = sector_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_sector_in = hit_sector_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      cmd_ready     = 1'b0;
      res_valid     = 1'b0;
      res.status    = ndt_pkg::ST_NOT_FOUND;
      res.sector    = '0;
      res.index     = '0;
      wr.write      = 1'b0;
      wr.clear      = 1'b0;
      wr.addr       = free_idx_ff;
      wr.name       = name_ff;
      wr.sector     = sector_ff;

      // Record the lowest match and the lowest free entry
      if (match && !hit_ff) begin
         hit_in        = 1'b1;
         hit_idx_in    = live_idx_ff;
         hit_sector_in = rd.sector;
      end
      if (empty && !free_ff) begin
         free_in     = 1'b1;
         free_idx_in = live_idx_ff;
      end

      unique case (state_ff)
         ndt_pkg::S_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               cmd_in    = cmd_code;
               name_in   = ndt_pkg::clean_name(cmd_name);
               sector_in = cmd_sector;
               size_in   = ndt_pkg::active_size(entries_in_use);
               idx_in    = '0;
               hit_in    = 1'b0;
               free_in   = 1'b0;
               if (ndt_pkg::active_size(entries_in_use) == '0) begin
                  state_in = ndt_pkg::S_APPLY;
               end else begin
                  state_in = ndt_pkg::S_SCAN;
               end
            end
         end
         ndt_pkg::S_SCAN: begin
            // Advance one entry per cycle; read data lands in the next cycle
            live_in = 1'b1;
            if (next_count == size_ff) begin
               state_in = ndt_pkg::S_DRAIN;
            end else begin
               idx_in = ndt_pkg::IDX_W'(next_count);
            end
         end
         ndt_pkg::S_DRAIN: begin
            state_in = ndt_pkg::S_APPLY;
         end
         ndt_pkg::S_APPLY: begin
            res_valid = 1'b1;
            case (cmd_ff)
               ndt_pkg::CMD_FIND: begin
                  if (hit_ff) begin
                     res.status = ndt_pkg::ST_OK;
                     res.sector = hit_sector_ff;
                     res.index  = ndt_pkg::INDEX_W'(hit_idx_ff);
                  end
               end
               ndt_pkg::CMD_ADD: begin
                  if (hit_ff) begin
                     res.status = ndt_pkg::ST_PRESENT;
                  end else if (free_ff) begin
                     res.status = ndt_pkg::ST_OK;
                     res.index  = ndt_pkg::INDEX_W'(free_idx_ff);
                     wr.write   = res_ready;
                  end else begin
                     res.status = ndt_pkg::ST_FULL;
                  end
               end
               ndt_pkg::CMD_REMOVE: begin
                  wr.addr = hit_idx_ff;
                  if (hit_ff) begin
                     res.status = ndt_pkg::ST_OK;
                     res.index  = ndt_pkg::INDEX_W'(hit_idx_ff);
                     wr.clear   = res_ready;
                  end
               end
               default: begin
                  res.status = ndt_pkg::ST_NOT_FOUND;
               end
            endcase
            if (res_ready) begin
               state_in = ndt_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ndt_pkg::S_IDLE;
         end
      endcase
   end

endmodule

/* hdl/name_keyed_directory_table_unit.sv */
`timescale 1ns / 1ps

// Directory table of 16 entries (valid mark, name of up to eight bytes, header
// sector). Each request on req_ carries find, add or remove and gives one
// response on rsp_. Names are cleaned at the byte after the first zero byte.
// A single name comparator walks the active entries one per cycle out of a
// registered-read memory. The active size is entries_in_use capped at 16; a new
// request is taken only after the previous response has entered the output
// register, and a full output register waits on rsp_tready.
// Find and remove act on the lowest valid match; add fails with "present" on
// a match, else fills the lowest free entry, else answers "full". Valid marks
// clear at reset; the table holds no other reset state. Write entries_in_use
// through csr_ only while no request is in flight.
module name_keyed_directory_table_unit (
   input  logic                        clock,
   input  logic                        reset,
   // req_tdata: command[1:0], file_name[65:2], header_sector[81:66], zero pad
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [ndt_pkg::REQ_W-1:0]   req_tdata,
   // rsp_tdata: status[1:0], found_sector[17:2], entry_index[21:18], zero pad
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [ndt_pkg::RSP_W-1:0]   rsp_tdata,
   // csr_data: entries_in_use
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [ndt_pkg::CFG_W-1:0]   csr_data
);

   logic [ndt_pkg::CFG_W-1:0]  size_ff;
   logic                       rsp_valid_ff;
   ndt_pkg::result_type        rsp_data_ff;
   logic                       res_valid;
   logic                       res_ready;
   ndt_pkg::result_type        res;
   logic [ndt_pkg::IDX_W-1:0]  rd_addr;
   ndt_pkg::rd_type            rd;
   ndt_pkg::wr_type            wr;

   // Size register: always accept the transfer
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= ndt_pkg::CFG_RESET;
      end else if (csr_valid) begin
         size_ff <= csr_data;
      end
   end

   ndt_entry_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .wr      (wr),
      .rd      (rd)
   );

   ndt_scan_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .entries_in_use (size_ff),
      .cmd_valid      (req_tvalid),
      .cmd_ready      (req_tready),
      .cmd_code       (req_tdata[1:0]),
      .cmd_name       (req_tdata[65:2]),
      .cmd_sector     (req_tdata[81:66]),
      .res_valid      (res_valid),
      .res_ready      (res_ready),
      .res            (res),
      .rd_addr        (rd_addr),
      .rd             (rd),
      .wr             (wr)
   );

   // Output register: load when empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready && res_valid) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(ndt_pkg::RSP_W - ndt_pkg::RSP_BITS){1'b0}},
                        rsp_data_ff.index, rsp_data_ff.sector, rsp_data_ff.status};

endmodule

/* test/tb_name_keyed_directory_table_unit.sv */
`timescale 1ns / 1ps

module tb_name_keyed_directory_table_unit;
   import ndt_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int POOL_SIZE    = 20;
   localparam int RANDOM_ITEMS = 1400;
   localparam int SETTLE_CYCLES = 30;
   localparam int IDLE_PCT     = 35;

   typedef struct {
      status_type          status;
      logic [SECTOR_W-1:0] sector;
      logic [INDEX_W-1:0]  index;
   } dir_result_type;

   // Cut a raw name at its first zero byte and at NAME_CHARS bytes
   function automatic logic [NAME_W-1:0] trim_name(input logic [NAME_W-1:0] raw);
      logic [NAME_W-1:0] kept;
      bit                ended;
      kept  = '0;
      ended = 1'b0;
      for (int b = 0; b < NAME_CHARS; b++) begin
         if (raw[8*b +: 8] == 8'h00) begin
            ended = 1'b1;
         end
         if (!ended) begin
            kept[8*b +: 8] = raw[8*b +: 8];
         end
      end
      return kept;
   endfunction

   // Directory predictor: own copy of the table, size register and awaited responses
   class directory_model;
      logic [CFG_W-1:0]    size_reg;
      bit                  slot_used   [TABLE_ENTRIES];
      logic [NAME_W-1:0]   slot_name   [TABLE_ENTRIES];
      logic [SECTOR_W-1:0] slot_sector [TABLE_ENTRIES];
      dir_result_type      awaited_results [$];
      int                  mismatches;
      int                  responses_checked;
      int                  status_seen [4];

      function new();
         size_reg = CFG_RESET;
         mismatches = 0;
         responses_checked = 0;
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            slot_used[i]   = 1'b0;
            slot_name[i]   = '0;
            slot_sector[i] = '0;
         end
         for (int s = 0; s < 4; s++) begin
            status_seen[s] = 0;
         end
      endfunction

      function int live_entries();
         return (int'(size_reg) > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(size_reg);
      endfunction

      // Apply one accepted request to the table and queue its response
      function void note_request(input logic [CMD_W-1:0] cmd, input logic [NAME_W-1:0] raw,
                                 input logic [SECTOR_W-1:0] sector);
         logic [NAME_W-1:0] key;
         dir_result_type    r;
         int                n;
         int                hit;
         int                free_slot;
         key = trim_name(raw);
         n = live_entries();
         r.status = ST_NOT_FOUND;
         r.sector = '0;
         r.index  = '0;
         hit = -1;
         free_slot = -1;
         for (int i = 0; i < n; i++) begin
            if (hit < 0 && slot_used[i] && slot_name[i] == key) begin
               hit = i;
            end
            if (free_slot < 0 && !slot_used[i]) begin
               free_slot = i;
            end
         end
         case (cmd)
            CMD_FIND: begin
               if (hit >= 0) begin
                  r.status = ST_OK;
                  r.sector = slot_sector[hit];
                  r.index  = hit[INDEX_W-1:0];
               end
            end
            CMD_ADD: begin
               if (hit >= 0) begin
                  r.status = ST_PRESENT;
               end else if (free_slot < 0) begin
                  r.status = ST_FULL;
               end else begin
                  slot_used[free_slot]   = 1'b1;
                  slot_name[free_slot]   = key;
                  slot_sector[free_slot] = sector;
                  r.status = ST_OK;
                  r.index  = free_slot[INDEX_W-1:0];
               end
            end
            CMD_REMOVE: begin
               if (hit >= 0) begin
                  slot_used[hit] = 1'b0;
                  r.status = ST_OK;
                  r.index  = hit[INDEX_W-1:0];
               end
            end
            default: begin
               // unused command: no change, not found
            end
         endcase
         awaited_results.push_back(r);
      endfunction

      task report_mismatch(input string msg);
         mismatches++;
         $display("[%0t] MISMATCH response %0d: %s", $realtime, responses_checked, msg);
      endtask

      // Compare one response transfer with the oldest awaited result
      task check_response(input logic [RSP_W-1:0] data);
         dir_result_type want;
         if (awaited_results.size() == 0) begin
            report_mismatch($sformatf("unexpected response %h", data));
            return;
         end
         want = awaited_results.pop_front();
         status_seen[want.status]++;
         if (data[1:0] !== want.status) begin
            report_mismatch($sformatf("status got %0d want %0d", data[1:0], want.status));
         end
         if (data[17:2] !== want.sector) begin
            report_mismatch($sformatf("found_sector got %h want %h", data[17:2], want.sector));
         end
         if (data[21:18] !== want.index) begin
            report_mismatch($sformatf("entry_index got %0d want %0d", data[21:18], want.index));
         end
         responses_checked++;
      endtask
   endclass

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_W-1:0]    req_tdata  = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_W-1:0]    rsp_tdata;
   logic                csr_valid  = 1'b0;
   logic                csr_ready;
   logic [CFG_W-1:0]    csr_data   = '0;

   bit                  no_idle = 1'b0;
   int                  requests_sent = 0;
   int                  size_writes = 0;
   logic [NAME_W-1:0]   name_pool [POOL_SIZE];
   directory_model      board = new();

   name_keyed_directory_table_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Check each response transfer, then stall the next cycle at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            board.check_response(rsp_tdata);
         end
         rsp_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Hold a request until its transfer, with random idle cycles ahead of it
   task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [NAME_W-1:0] raw,
                               input logic [SECTOR_W-1:0] sector);
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_W - REQ_BITS){1'b0}}, sector, raw, cmd};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      board.note_request(cmd, raw, sector);
      requests_sent++;
   endtask

   // Drop valid, wait for every response, then let the scan finish
   task automatic drain_requests();
      req_tvalid <= 1'b0;
      while (board.awaited_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_size(input logic [CFG_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      csr_valid <= 1'b0;
      board.size_reg = value;
      size_writes++;
   endtask

   // Fill the bytes past the terminator with junk half of the time
   function automatic logic [NAME_W-1:0] dress_name(input logic [NAME_W-1:0] clean);
      logic [NAME_W-1:0] raw;
      int                len;
      bit                messy;
      raw   = clean;
      len   = 0;
      messy = 1'($urandom_range(1));
      while (len < NAME_CHARS && clean[8*len +: 8] != 8'h00) begin
         len++;
      end
      for (int b = len + 1; b < NAME_W / 8; b++) begin
         if (messy) begin
            raw[8*b +: 8] = 8'($urandom);
         end
      end
      return raw;
   endfunction

   // Build names of random length up to NAME_CHARS; some extend the one before to test prefixes
   task automatic build_name_pool();
      int len;
      for (int i = 0; i < POOL_SIZE; i++) begin
         name_pool[i] = '0;
         len = $urandom_range(0, NAME_CHARS);
         if (i > 0 && (i % 3) == 1 && name_pool[i-1][NAME_W-8 +: 8] == 8'h00) begin
            name_pool[i] = name_pool[i-1];
            len = 0;
            while (name_pool[i][8*len +: 8] != 8'h00) begin
               len++;
            end
            name_pool[i][8*len +: 8] = 8'($urandom_range(1, 255));
         end else begin
            for (int b = 0; b < len; b++) begin
               name_pool[i][8*b +: 8] = 8'($urandom_range(1, 255));
            end
         end
      end
   endtask

   // Random mix of commands, mostly on pooled names
   task automatic run_random_phase(input int count);
      logic [CMD_W-1:0]  cmd;
      logic [NAME_W-1:0] raw;
      int                pick;
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            cmd = CMD_ADD;
         end else if (pick < 70) begin
            cmd = CMD_FIND;
         end else if (pick < 95) begin
            cmd = CMD_REMOVE;
         end else begin
            cmd = CMD_UNUSED;
         end
         if ($urandom_range(99) < 8) begin
            raw = {$urandom, $urandom};
            if (cmd == CMD_ADD) begin
               name_pool[$urandom_range(POOL_SIZE - 1)] = trim_name(raw);
            end
         end else begin
            raw = dress_name(name_pool[$urandom_range(POOL_SIZE - 1)]);
         end
         send_request(cmd, raw, 16'($urandom));
      end
   endtask

   initial begin
      logic [CFG_W-1:0] phase_sizes [10];
      logic [CFG_W-1:0] size;
      int               random_done;
      int               phase;
      int               count;
      phase_sizes = '{5'd16, 5'd1, 5'd2, 5'd0, 5'd31, 5'd5, 5'd16, 5'd8, 5'd17, 5'd3};
      build_name_pool();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty table, extreme names, junk after terminator, duplicates
      send_request(CMD_FIND,   64'h0, 16'h0);
      send_request(CMD_ADD,    64'h41, 16'h0000);
      send_request(CMD_ADD,    '1, 16'hFFFF);
      send_request(CMD_ADD,    64'hDEADBEEF_0000_4241, 16'h5A5A);
      send_request(CMD_FIND,   64'h12345678_9A00_4241, 16'h0);
      send_request(CMD_FIND,   64'h434241, 16'h0);
      send_request(CMD_ADD,    64'h4241, 16'h0001);
      send_request(CMD_FIND,   '1, 16'h0);
      send_request(CMD_REMOVE, 64'h41, 16'h0);
      send_request(CMD_FIND,   64'h41, 16'h0);
      send_request(CMD_REMOVE, 64'h41, 16'hFFFF);
      send_request(CMD_ADD,    64'h0, 16'h1234);
      send_request(CMD_FIND,   64'hFFFFFFFF_FFFF_FF00, 16'h0);
      send_request(CMD_UNUSED, '1, 16'hFFFF);
      send_request(CMD_FIND,   '1, 16'h0);
      drain_requests();

      // Shrink so the table is full, then to zero, then past the built depth
      write_size(5'd3);
      send_request(CMD_ADD,    64'h43, 16'hAAAA);
      send_request(CMD_FIND,   64'h4241, 16'h0);
      drain_requests();
      write_size(5'd0);
      send_request(CMD_FIND,   '1, 16'h0);
      send_request(CMD_ADD,    64'h44, 16'h5555);
      send_request(CMD_REMOVE, 64'h4241, 16'h0);
      drain_requests();
      write_size(5'd31);
      send_request(CMD_FIND,   64'h4241, 16'h0);
      send_request(CMD_REMOVE, '1, 16'h0);
      drain_requests();

      // Random phases over several table sizes, one of them with no idling
      random_done = 0;
      phase = 0;
      while (random_done < RANDOM_ITEMS) begin
         size = (phase < 10) ? phase_sizes[phase] : 5'($urandom_range(1, TABLE_ENTRIES));
         count = (size == 0) ? 30 : $urandom_range(100, 160);
         write_size(size);
         no_idle = (phase == 6);
         run_random_phase(count);
         drain_requests();
         no_idle = 1'b0;
         random_done += count;
         phase++;
      end

      $display("Ran %0d requests over %0d table size settings, %0d responses checked.",
               requests_sent, size_writes, board.responses_checked);
      $display("Responses: ok %0d, not found %0d, already present %0d, full %0d.",
               board.status_seen[ST_OK], board.status_seen[ST_NOT_FOUND],
               board.status_seen[ST_PRESENT], board.status_seen[ST_FULL]);
      if (board.mismatches == 0 && board.awaited_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #5000000;
      $display("FAILURE");
      $finish;
   end

endmodule
